// ----- hdl/rrts_pkg.sv -----
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the round-robin task scheduler: item formats,
// command and status codes, slot states, memory port bundles and fsm states.
// ----------------------------------------------------------------------------
package rrts_pkg;

   localparam int SLOT_COUNT = 1024;
   localparam int SLOT_IDX_W = $clog2(SLOT_COUNT);
   localparam int COUNT_W    = SLOT_IDX_W + 1;
   localparam int TASK_W     = 10;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_RUN   = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_SLEEP = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_FREE = 2'd1,
      STATUS_IGNORED = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SLOT_FREE      = 2'd0,
      SLOT_ALLOCATED = 2'd1,
      SLOT_RUNNING   = 2'd2
   } slot_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [TASK_W-1:0] task_number;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [TASK_W-1:0] chosen_task;
      logic              do_switch;
   } rsp_type;

   // slot table memory port
   typedef struct packed {
      logic                  we;
      logic [SLOT_IDX_W-1:0] waddr;
      logic [1:0]            wdata;
      logic [SLOT_IDX_W-1:0] raddr;
   } ss_port_type;

   // run list memory port
   typedef struct packed {
      logic                  we;
      logic [SLOT_IDX_W-1:0] waddr;
      logic [TASK_W-1:0]     wdata;
      logic [SLOT_IDX_W-1:0] raddr;
   } rl_port_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC,
      ST_RUN,
      ST_SLP_CHK,
      ST_SLP_FIND,
      ST_SLP_SHIFT,
      ST_OUT
   } state_type;

endpackage

// ----- hdl/round_robin_task_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_unit
// Task slot table and compact round-robin run list with allocate, run, tick
// and sleep commands; one result per command.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on rsp_item for exactly one cycle with rsp_valid high, and cannot
// be held off. After reset a clearing pass walks the slot table and run list
// memories, with busy high. Allocate walks the slot table one entry per
// cycle through its memory read port, up to the first free slot. Sleep
// searches the run list one entry per cycle and then compacts it one entry
// per cycle through the run list memory.
module round_robin_task_scheduler_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rrts_pkg::req_type req_item,
   output logic              rsp_valid,
   output rrts_pkg::rsp_type rsp_item
);

   rrts_pkg::ss_port_type            ss_port;
   rrts_pkg::rl_port_type            rl_port;
   logic [1:0]                       ss_rdata;
   logic [rrts_pkg::TASK_W-1:0]      rl_rdata;

   rrts_ram #(
      .WIDTH(2),
      .DEPTH(rrts_pkg::SLOT_COUNT)
   ) u_slot_ram (
      .clock (clock),
      .we    (ss_port.we),
      .waddr (ss_port.waddr),
      .wdata (ss_port.wdata),
      .raddr (ss_port.raddr),
      .rdata (ss_rdata)
   );

   rrts_ram #(
      .WIDTH(rrts_pkg::TASK_W),
      .DEPTH(rrts_pkg::SLOT_COUNT)
   ) u_list_ram (
      .clock (clock),
      .we    (rl_port.we),
      .waddr (rl_port.waddr),
      .wdata (rl_port.wdata),
      .raddr (rl_port.raddr),
      .rdata (rl_rdata)
   );

   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .ss_port   (ss_port),
      .ss_rdata  (ss_rdata),
      .rl_port   (rl_port),
      .rl_rdata  (rl_rdata)
   );

endmodule

// ----- hdl/rrts_ram.sv -----
// ----------------------------------------------------------------------------
// rrts_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/rrts_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrts_ctrl
// Command sequencer: clearing pass, slot search, run list append, tick
// rotation and sleep search with list compaction over the two memories.
// ----------------------------------------------------------------------------
module rrts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  rrts_pkg::req_type    req_item,
   output logic                 rsp_valid,
   output rrts_pkg::rsp_type    rsp_item,
   output rrts_pkg::ss_port_type ss_port,
   input  logic [1:0]           ss_rdata,
   output rrts_pkg::rl_port_type rl_port,
   input  logic [rrts_pkg::TASK_W-1:0] rl_rdata
);

   localparam int IW = rrts_pkg::SLOT_IDX_W;
   localparam int CW = rrts_pkg::COUNT_W;
   localparam int TW = rrts_pkg::TASK_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(rrts_pkg::SLOT_COUNT - 1);

   rrts_pkg::state_type state_ff, state_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [IW-1:0]       pos_ff, pos_in;
   logic [TW-1:0]       task_ff, task_in;
   logic                cur_ff, cur_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rrts_pkg::rsp_type   rsp_item_ff, rsp_item_in;

   logic                out_of_range;
   logic [CW-1:0]       pos_inc;
   logic [IW-1:0]       pos_next;
   logic [IW-1:0]       pos_wrap;

   assign out_of_range = {1'b0, req_item.task_number} >= (TW + 1)'(rrts_pkg::SLOT_COUNT);
   assign pos_inc      = CW'(pos_ff) + CW'(1);
   assign pos_next     = (pos_inc >= count_ff) ? '0 : pos_inc[IW-1:0];
   assign pos_wrap     = (CW'(pos_ff) >= count_ff) ? '0 : pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrts_pkg::ST_CLEAR;
         idx_ff       <= '0;
         count_ff     <= CW'(1);
         pos_ff       <= '0;
         cur_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      task_ff     <= task_in;
      rsp_item_ff <= rsp_item_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      task_in      = task_ff;
      cur_in       = cur_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = '0;
      ss_port      = '0;
      rl_port      = '0;
      ss_port.raddr = IW'(task_ff);

      case (state_ff)
         rrts_pkg::ST_CLEAR: begin
            ss_port.we    = 1'b1;
            ss_port.waddr = idx_ff;
            ss_port.wdata = (idx_ff == '0) ? rrts_pkg::SLOT_RUNNING : rrts_pkg::SLOT_FREE;
            rl_port.we    = 1'b1;
            rl_port.waddr = idx_ff;
            rl_port.wdata = '0;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = rrts_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end

         rrts_pkg::ST_IDLE: begin
            ss_port.raddr = IW'(req_item.task_number);
            if (start) begin
               task_in = req_item.task_number;
               case (req_item.cmd)
                  rrts_pkg::CMD_ALLOC: begin
                     ss_port.raddr = '0;
                     idx_in        = '0;
                     state_in      = rrts_pkg::ST_ALLOC;
                  end
                  rrts_pkg::CMD_RUN: begin
                     if (out_of_range) begin
                        rsp_valid_in       = 1'b1;
                        rsp_item_in.status = rrts_pkg::STATUS_IGNORED;
                     end else begin
                        state_in = rrts_pkg::ST_RUN;
                     end
                  end
                  rrts_pkg::CMD_TICK: begin
                     if (count_ff >= CW'(2)) begin
                        pos_in        = pos_next;
                        rl_port.raddr = pos_next;
                        state_in      = rrts_pkg::ST_OUT;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  rrts_pkg::CMD_SLEEP: begin
                     if (out_of_range) begin
                        rsp_valid_in       = 1'b1;
                        rsp_item_in.status = rrts_pkg::STATUS_IGNORED;
                     end else begin
                        state_in = rrts_pkg::ST_SLP_CHK;
                     end
                  end
                  default: begin
                     state_in = rrts_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         // streaming scan: data for idx_ff arrives while idx_ff + 1 is read
         rrts_pkg::ST_ALLOC: begin
            ss_port.raddr = idx_ff + IW'(1);
            if (ss_rdata == rrts_pkg::SLOT_FREE) begin
               ss_port.we              = 1'b1;
               ss_port.waddr           = idx_ff;
               ss_port.wdata           = rrts_pkg::SLOT_ALLOCATED;
               rsp_valid_in            = 1'b1;
               rsp_item_in.chosen_task = TW'(idx_ff);
               state_in                = rrts_pkg::ST_IDLE;
            end else if (idx_ff == LAST_IDX) begin
               rsp_valid_in       = 1'b1;
               rsp_item_in.status = rrts_pkg::STATUS_NO_FREE;
               state_in           = rrts_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end

         rrts_pkg::ST_RUN: begin
            rsp_valid_in = 1'b1;
            state_in     = rrts_pkg::ST_IDLE;
            if (ss_rdata == rrts_pkg::SLOT_RUNNING) begin
               rsp_item_in.status = rrts_pkg::STATUS_OK;
            end else if (count_ff >= CW'(rrts_pkg::SLOT_COUNT)) begin
               rsp_item_in.status = rrts_pkg::STATUS_FULL;
            end else begin
               ss_port.we    = 1'b1;
               ss_port.waddr = IW'(task_ff);
               ss_port.wdata = rrts_pkg::SLOT_RUNNING;
               rl_port.we    = 1'b1;
               rl_port.waddr = count_ff[IW-1:0];
               rl_port.wdata = task_ff;
               count_in      = count_ff + CW'(1);
            end
         end

         rrts_pkg::ST_SLP_CHK: begin
            if (ss_rdata != rrts_pkg::SLOT_RUNNING) begin
               rsp_valid_in       = 1'b1;
               rsp_item_in.status = rrts_pkg::STATUS_IGNORED;
               state_in           = rrts_pkg::ST_IDLE;
            end else begin
               ss_port.we    = 1'b1;
               ss_port.waddr = IW'(task_ff);
               ss_port.wdata = rrts_pkg::SLOT_ALLOCATED;
               if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  state_in     = rrts_pkg::ST_IDLE;
               end else begin
                  rl_port.raddr = '0;
                  idx_in        = '0;
                  state_in      = rrts_pkg::ST_SLP_FIND;
               end
            end
         end

         rrts_pkg::ST_SLP_FIND: begin
            rl_port.raddr = idx_ff + IW'(1);
            if (rl_rdata == task_ff) begin
               count_in = count_ff - CW'(1);
               cur_in   = (idx_ff == pos_ff);
               if (idx_ff < pos_ff) begin
                  pos_in = pos_ff - IW'(1);
               end
               state_in = rrts_pkg::ST_SLP_SHIFT;
            end else if (CW'(idx_ff) + CW'(1) >= count_ff) begin
               // task not in the list: slot is only marked allocated
               rsp_valid_in = 1'b1;
               state_in     = rrts_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end

         // reads run two entries ahead of the write, so no overlap
         rrts_pkg::ST_SLP_SHIFT: begin
            if (CW'(idx_ff) < count_ff) begin
               rl_port.we    = 1'b1;
               rl_port.waddr = idx_ff;
               rl_port.wdata = rl_rdata;
               rl_port.raddr = idx_ff + IW'(2);
               idx_in        = idx_ff + IW'(1);
            end else if (!cur_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = rrts_pkg::ST_IDLE;
            end else begin
               pos_in = pos_wrap;
               if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  state_in     = rrts_pkg::ST_IDLE;
               end else begin
                  rl_port.raddr = pos_wrap;
                  state_in      = rrts_pkg::ST_OUT;
               end
            end
         end

         rrts_pkg::ST_OUT: begin
            rsp_valid_in            = 1'b1;
            rsp_item_in.chosen_task = rl_rdata;
            rsp_item_in.do_switch   = 1'b1;
            state_in                = rrts_pkg::ST_IDLE;
         end

         default: begin
            state_in = rrts_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != rrts_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // clearing pass holds off items right after reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("block not busy after reset");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(rrts_pkg::SLOT_COUNT))
      else $error("running count out of range");

   a_pos_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rrts_pkg::ST_IDLE) |-> (CW'(pos_ff) < count_ff || count_ff == '0))
      else $error("position outside run list");

   a_item_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted item neither in work nor answered");

endmodule

// ----- tb/rrts_scheduler_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_scheduler_checker
// Watches the command and response channels of the round-robin task
// scheduler, keeps its own copy of the slot table, run list and position,
// predicts each response and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module rrts_scheduler_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  rrts_pkg::req_type req_item,
   input  logic              rsp_valid,
   input  rrts_pkg::rsp_type rsp_item,
   output int                fail_count,
   output int                pending_count,
   output int                result_count,
   output int                switch_count,
   output int                no_free_count,
   output int                ignored_count
);

   localparam int NSLOT = rrts_pkg::SLOT_COUNT;
   localparam int IW    = rrts_pkg::SLOT_IDX_W;
   localparam int CW    = rrts_pkg::COUNT_W;
   localparam int TW    = rrts_pkg::TASK_W;

   rrts_pkg::slot_type slot_state [NSLOT];
   logic [TW-1:0]      run_order  [NSLOT];
   logic [CW-1:0]      run_count;
   logic [IW-1:0]      run_pos;

   rrts_pkg::rsp_type awaited_rsp [$];
   int      mismatch_total = 0;
   int      rsp_total      = 0;
   int      switch_total   = 0;
   int      no_free_total  = 0;
   int      ignored_total  = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      result_count  = 0;
      switch_count  = 0;
      no_free_count = 0;
      ignored_count = 0;
   end

   // advances the scheduler copy by one command and returns its response
   function automatic rrts_pkg::rsp_type schedule_step(rrts_pkg::req_type r);
      rrts_pkg::rsp_type res;
      int      t, cnt, pos, idx, i;
      logic    found, was_current;
      res.status      = rrts_pkg::STATUS_OK;
      res.chosen_task = '0;
      res.do_switch   = 1'b0;
      t   = int'(r.task_number);
      cnt = int'(run_count);
      pos = int'(run_pos);
      case (r.cmd)
         rrts_pkg::CMD_ALLOC: begin
            found = 1'b0;
            for (i = 0; i < NSLOT; i++) begin
               if (!found && slot_state[i] == rrts_pkg::SLOT_FREE) begin
                  found           = 1'b1;
                  slot_state[i]   = rrts_pkg::SLOT_ALLOCATED;
                  res.chosen_task = TW'(i);
               end
            end
            if (!found) res.status = rrts_pkg::STATUS_NO_FREE;
         end
         rrts_pkg::CMD_RUN: begin
            if (t >= NSLOT) begin
               res.status = rrts_pkg::STATUS_IGNORED;
            end else if (slot_state[t] == rrts_pkg::SLOT_RUNNING) begin
               res.status = rrts_pkg::STATUS_OK;
            end else if (cnt >= NSLOT) begin
               res.status = rrts_pkg::STATUS_FULL;
            end else begin
               slot_state[t]  = rrts_pkg::SLOT_RUNNING;
               run_order[cnt] = TW'(t);
               cnt++;
            end
         end
         rrts_pkg::CMD_TICK: begin
            if (cnt >= 2) begin
               pos++;
               if (pos >= cnt) pos = 0;
               res.chosen_task = run_order[pos];
               res.do_switch   = 1'b1;
            end
         end
         rrts_pkg::CMD_SLEEP: begin
            if (t >= NSLOT || slot_state[t] != rrts_pkg::SLOT_RUNNING) begin
               res.status = rrts_pkg::STATUS_IGNORED;
            end else begin
               was_current = (pos < cnt) && (run_order[pos] == TW'(t));
               idx = cnt;
               for (i = 0; i < cnt; i++) begin
                  if (idx == cnt && run_order[i] == TW'(t)) idx = i;
               end
               slot_state[t] = rrts_pkg::SLOT_ALLOCATED;
               if (idx < cnt) begin
                  cnt--;
                  if (idx < pos) pos--;
                  // close the gap left by the removed entry
                  for (i = idx; i < cnt; i++) run_order[i] = run_order[i+1];
                  if (was_current) begin
                     if (pos >= cnt) pos = 0;
                     if (cnt != 0) begin
                        res.chosen_task = run_order[pos];
                        res.do_switch   = 1'b1;
                     end
                  end
               end
            end
         end
      endcase
      run_count = CW'(cnt);
      run_pos   = IW'(pos);
      return res;
   endfunction

   always @(posedge clock) begin
      rrts_pkg::rsp_type want;
      logic    bad;
      int      i;
      if (reset) begin
         for (i = 0; i < NSLOT; i++) begin
            slot_state[i] = rrts_pkg::SLOT_FREE;
            run_order[i]  = '0;
         end
         slot_state[0] = rrts_pkg::SLOT_RUNNING;
         run_count     = CW'(1);
         run_pos       = '0;
         awaited_rsp.delete();
      end else begin
         if (rsp_valid) begin
            rsp_total++;
            if (rsp_item.do_switch) switch_total++;
            if (rsp_item.status == rrts_pkg::STATUS_NO_FREE) no_free_total++;
            if (rsp_item.status == rrts_pkg::STATUS_IGNORED) ignored_total++;
            if (awaited_rsp.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("%0t: unexpected response status %0d task %0d switch %0d",
                           $realtime, rsp_item.status, rsp_item.chosen_task,
                           rsp_item.do_switch);
            end else begin
               want = awaited_rsp.pop_front();
               bad  = (rsp_item.status !== want.status) ||
                      (rsp_item.chosen_task !== want.chosen_task) ||
                      (rsp_item.do_switch !== want.do_switch);
               if (bad) begin
                  mismatch_total++;
                  if (mismatch_total <= 10)
                     $display({"%0t: response mismatch: expected status %0d task %0d ",
                               "switch %0d, got status %0d task %0d switch %0d"},
                              $realtime, want.status, want.chosen_task, want.do_switch,
                              rsp_item.status, rsp_item.chosen_task, rsp_item.do_switch);
               end
            end
         end
         if (start && !busy) awaited_rsp.push_back(schedule_step(req_item));
      end
      fail_count    <= mismatch_total;
      pending_count <= awaited_rsp.size();
      result_count  <= rsp_total;
      switch_count  <= switch_total;
      no_free_count <= no_free_total;
      ignored_count <= ignored_total;
   end

endmodule

// ----- tb/tb_round_robin_task_scheduler_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_task_scheduler_unit
// Drives allocate, run, tick and sleep commands into the scheduler in bursts
// with random gaps: a directed opening, a random mix centered on a small task
// pool, and a short random tail. A checker beside the block predicts and
// compares every response.
// ----------------------------------------------------------------------------
module tb_round_robin_task_scheduler_unit;

   localparam int TW = rrts_pkg::TASK_W;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              start     = 1'b0;
   rrts_pkg::req_type req_item  = '0;
   logic              busy;
   logic              rsp_valid;
   rrts_pkg::rsp_type rsp_item;

   int fail_count, pending_count, result_count;
   int switch_count, no_free_count, ignored_count;
   int burst_left = 0;

   round_robin_task_scheduler_unit uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   rrts_scheduler_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_item      (rsp_item),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count),
      .switch_count  (switch_count),
      .no_free_count (no_free_count),
      .ignored_count (ignored_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("tb_round_robin_task_scheduler_unit NOT OK");
      $finish;
   end

   // called at a falling edge; returns at a falling edge after acceptance and any gap
   task automatic send_item(input rrts_pkg::cmd_type c, input logic [TW-1:0] t);
      req_item <= '{cmd: c, task_number: t};
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      // bursts of items, sometimes long ones, most of them followed by a short gap
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 11);
         if ($urandom_range(0, 3) != 0) begin
            start    <= 1'b0;
            req_item <= rrts_pkg::req_type'($urandom);
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   endtask

   // mostly a small pool so the run list stays short and sleeps hit it
   function automatic logic [TW-1:0] pick_task();
      if ($urandom_range(0, 9) < 7) return TW'($urandom_range(0, 15));
      return TW'($urandom_range(0, rrts_pkg::SLOT_COUNT - 1));
   endfunction

   initial begin
      int n, roll;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed opening
      send_item(rrts_pkg::CMD_TICK,  10'd0);    // single running task, no switch
      send_item(rrts_pkg::CMD_RUN,   10'd0);    // already running
      send_item(rrts_pkg::CMD_SLEEP, 10'd5);    // free slot
      send_item(rrts_pkg::CMD_ALLOC, 10'd0);
      send_item(rrts_pkg::CMD_SLEEP, 10'd1);    // allocated but not running
      send_item(rrts_pkg::CMD_SLEEP, 10'd0);    // current task sleeps, list empties
      send_item(rrts_pkg::CMD_TICK,  10'd0);    // empty list
      send_item(rrts_pkg::CMD_SLEEP, 10'd0);
      send_item(rrts_pkg::CMD_RUN,   10'd1023);
      send_item(rrts_pkg::CMD_RUN,   10'd0);
      send_item(rrts_pkg::CMD_RUN,   10'd512);
      send_item(rrts_pkg::CMD_TICK,  10'd0);
      send_item(rrts_pkg::CMD_TICK,  10'd0);
      send_item(rrts_pkg::CMD_TICK,  10'd0);    // wraps
      send_item(rrts_pkg::CMD_SLEEP, 10'd1023);
      send_item(rrts_pkg::CMD_RUN,   10'd341);
      send_item(rrts_pkg::CMD_RUN,   10'd682);
      send_item(rrts_pkg::CMD_TICK,  10'd0);
      send_item(rrts_pkg::CMD_SLEEP, 10'd341);
      send_item(rrts_pkg::CMD_ALLOC, 10'd1023);
      send_item(rrts_pkg::CMD_ALLOC, 10'd0);
      send_item(rrts_pkg::CMD_SLEEP, 10'd512);
      send_item(rrts_pkg::CMD_TICK,  10'd0);

      // random mix
      for (n = 0; n < 540; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 12)      send_item(rrts_pkg::CMD_ALLOC, TW'($urandom));
         else if (roll < 47) send_item(rrts_pkg::CMD_RUN, pick_task());
         else if (roll < 74) send_item(rrts_pkg::CMD_TICK, TW'($urandom));
         else                send_item(rrts_pkg::CMD_SLEEP, pick_task());
      end

      // a few closing allocations and a short random tail
      for (n = 0; n < 3; n++) send_item(rrts_pkg::CMD_ALLOC, TW'($urandom));
      for (n = 0; n < 12; n++) begin
         roll = $urandom_range(0, 2);
         if (roll == 0)      send_item(rrts_pkg::CMD_TICK, TW'($urandom));
         else if (roll == 1) send_item(rrts_pkg::CMD_SLEEP, TW'($urandom));
         else                send_item(rrts_pkg::CMD_RUN, pick_task());
      end

      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (1100) @(posedge clock);

      $display("run covered %0d responses, %0d context switches, %0d with no free slot,",
               result_count, switch_count, no_free_count);
      $display("%0d ignored commands, over a directed opening and a random command mix",
               ignored_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_round_robin_task_scheduler_unit OK");
      end else begin
         $display("tb_round_robin_task_scheduler_unit NOT OK");
      end
      $finish;
   end

endmodule
